// ----- rtl/hpid_pkg.sv -----
// Shared types and fixed constants of the heater PID controller.
// No dependencies; imported by every module of the block.
package hpid_pkg;

    localparam int MEAS_W      = 12;  // temperature in quarter degrees
    localparam int ERR_W       = 13;  // signed difference of two temperatures
    localparam int CFG_W       = 24;  // widest configuration register
    localparam int PGAIN_W     = 20;
    localparam int IGAIN_W     = 16;
    localparam int DGAIN_W     = 20;
    localparam int ACC_W       = 24;
    localparam int DUTY_W      = 7;
    localparam int PTERM_W     = 16;
    localparam int ITERM_W     = 23;
    localparam int DTERM_W     = 14;

    localparam int TERM_SHIFT  = 17;  // terms are divided by 131072
    localparam int DUTY_MAX    = 100;
    localparam int NEAR_BAND   = 16;
    localparam int HEAT_SHIFT  = 3;   // extra 8x error when just below set point
    localparam int COOL_SHIFT  = 4;   // extra 16x error when just above set point

    localparam logic [PGAIN_W-1:0] PGAIN_RST = PGAIN_W'(32768);
    localparam logic [IGAIN_W-1:0] IGAIN_RST = IGAIN_W'(50);
    localparam logic [DGAIN_W-1:0] DGAIN_RST = DGAIN_W'(327680);
    localparam logic [ACC_W-1:0]   ILIMIT_RST = ACC_W'(13107200);

    typedef enum logic [1:0] {
        REG_PROP_GAIN   = 2'd0,
        REG_INTEG_GAIN  = 2'd1,
        REG_DERIV_GAIN  = 2'd2,
        REG_INTEG_LIMIT = 2'd3
    } reg_idx_t;

    // history control from the pipeline
    typedef struct packed {
        logic shift;   // a sample leaves the input stage this cycle
        logic prime;   // first sample since reset: fill the whole window
    } hist_ctrl_t;

endpackage

// ----- rtl/heater_pid_controller_unit.sv -----
// Heater PID controller: input stage, integral/slope stage, product stage and
// result register. Depends on hpid_pkg and hpid_history.
//
// Usage:
//   s_ channel: one beat carries s_measured and s_target (quarter degrees).
//   m_ channel: one beat per input beat with m_duty (0..100 percent) and the
//   P, I and D terms, each divided by 131072 toward zero, P and D saturated.
//   cfg port: cfg_wr_en writes cfg_wdata into register cfg_addr at once
//   (0 prop_gain, 1 integ_gain, 2 deriv_gain, 3 integ_limit); write only
//   while no beat is in flight.
// Timing:
//   Four register stages: input, integral/slope, product and result; a beat
//   uses each in turn. One beat per cycle is taken while m_ready stays high;
//   the rate is set by the per-stage handshake, each stage holds one beat.
//   The integral accumulator and measurement window update as a beat leaves
//   the input stage, so back-to-back beats see each other in order.
// Reset: aresetn clears all stages, the accumulator and the priming flag and
//   reloads the gain defaults. The first beat after reset fills the window.
// Stall: when m_ready is low the result holds and stages behind it fill up;
//   s_ready drops only once every stage holds a beat.
module heater_pid_controller_unit
    import hpid_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_wr_en,
    input  logic [1:0]                cfg_addr,
    input  logic [CFG_W-1:0]          cfg_wdata,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [MEAS_W-1:0]         s_measured,
    input  logic [MEAS_W-1:0]         s_target,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [DUTY_W-1:0]         m_duty,
    output logic signed [PTERM_W-1:0] m_prop_term,
    output logic [ITERM_W-1:0]        m_integ_term,
    output logic signed [DTERM_W-1:0] m_deriv_term
);

    localparam int ACC_CALC_W = ACC_W + 3;
    localparam int P_W        = ERR_W + PGAIN_W + 1;
    localparam int I_W        = ACC_W + IGAIN_W;
    localparam int D_W        = ERR_W + DGAIN_W;
    localparam int SUM_W      = I_W + 2;
    localparam int SUMQ_W     = SUM_W - TERM_SHIFT;
    localparam int PQ_W       = P_W - TERM_SHIFT;
    localparam int DQ_W       = D_W - TERM_SHIFT;

    localparam logic signed [SUM_W-1:0] SUM_BIAS = SUM_W'((1 << TERM_SHIFT) - 1);
    localparam logic signed [P_W-1:0]   P_BIAS   = P_W'((1 << TERM_SHIFT) - 1);
    localparam logic signed [D_W-1:0]   D_BIAS   = D_W'((1 << TERM_SHIFT) - 1);

    // configuration
    logic [PGAIN_W-1:0] prop_gain_reg;
    logic [IGAIN_W-1:0] integ_gain_reg;
    logic [DGAIN_W-1:0] deriv_gain_reg;
    logic [ACC_W-1:0]   integ_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= PGAIN_RST;
            integ_gain_reg  <= IGAIN_RST;
            deriv_gain_reg  <= DGAIN_RST;
            integ_limit_reg <= ILIMIT_RST;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_addr))
                REG_PROP_GAIN:   prop_gain_reg   <= cfg_wdata[PGAIN_W-1:0];
                REG_INTEG_GAIN:  integ_gain_reg  <= cfg_wdata[IGAIN_W-1:0];
                REG_DERIV_GAIN:  deriv_gain_reg  <= cfg_wdata[DGAIN_W-1:0];
                REG_INTEG_LIMIT: integ_limit_reg <= cfg_wdata[ACC_W-1:0];
                default: ;
            endcase
        end
    end

    // stage handshake: a stage takes a beat when it is empty or drains
    logic v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic out_free, s3_free, s2_free, s1_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s3_free  = !v3_reg || out_free;
    assign s2_free  = !v2_reg || s3_free;
    assign s1_free  = !v1_reg || s2_free;
    assign s_ready  = s1_free;
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s1_free)  v1_reg      <= s_valid;
            if (s2_free)  v2_reg      <= v1_reg;
            if (s3_free)  v3_reg      <= v2_reg;
            if (out_free) m_valid_reg <= v3_reg;
        end
    end

    // stage 1: input register
    logic [MEAS_W-1:0] s1_meas_reg, s1_tgt_reg;

    always_ff @(posedge aclk) begin
        if (s1_free && s_valid) begin
            s1_meas_reg <= s_measured;
            s1_tgt_reg  <= s_target;
        end
    end

    // stage 1 -> 2: error, integral update, windowed slope
    logic                         adv1;
    logic                         primed_reg;
    logic [ACC_W-1:0]             acc_reg, acc_next;
    logic signed [ERR_W-1:0]      err;
    logic signed [ACC_CALC_W-1:0] err_x, acc_inc, acc_sum, limit_x;
    logic signed [ERR_W-1:0]      delta;
    hist_ctrl_t                   hist_ctrl;

    assign adv1            = v1_reg && s2_free;
    assign hist_ctrl.shift = adv1;
    assign hist_ctrl.prime = !primed_reg;

    hpid_history #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_history (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (hist_ctrl),
        .meas    (s1_meas_reg),
        .delta   (delta)
    );

    always_comb begin
        err     = signed'({1'b0, s1_tgt_reg}) - signed'({1'b0, s1_meas_reg});
        err_x   = ACC_CALC_W'(err);
        limit_x = signed'(ACC_CALC_W'(integ_limit_reg));
        if (err > ERR_W'(0)) begin
            acc_inc = err_x;
            if (err < ERR_W'(NEAR_BAND)) acc_inc = acc_inc + (err_x <<< HEAT_SHIFT);
        end else begin
            // divide by 4 toward zero
            acc_inc = (err_x + (err_x[ACC_CALC_W-1] ? ACC_CALC_W'(3) : ACC_CALC_W'(0))) >>> 2;
            if (err > -ERR_W'(NEAR_BAND)) acc_inc = acc_inc + (err_x <<< COOL_SHIFT);
        end
        acc_sum = signed'(ACC_CALC_W'(acc_reg)) + acc_inc;
        if (acc_sum < ACC_CALC_W'(0))
            acc_next = '0;
        else if (acc_sum > limit_x)
            acc_next = integ_limit_reg;
        else
            acc_next = acc_sum[ACC_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            primed_reg <= 1'b0;
        end else if (adv1) begin
            acc_reg    <= acc_next;
            primed_reg <= 1'b1;
        end
    end

    logic signed [ERR_W-1:0] s2_err_reg, s2_delta_reg;
    logic [ACC_W-1:0]        s2_acc_reg;

    always_ff @(posedge aclk) begin
        if (adv1) begin
            s2_err_reg   <= err;
            s2_delta_reg <= delta;
            s2_acc_reg   <= acc_next;
        end
    end

    // stage 2 -> 3: gain products
    logic signed [P_W-1:0] p_prod;
    logic [I_W-1:0]        i_prod;
    logic signed [D_W-1:0] d_prod, d_brake;

    always_comb begin
        p_prod  = P_W'(s2_err_reg) * signed'(P_W'(prop_gain_reg));
        i_prod  = I_W'(s2_acc_reg) * I_W'(integ_gain_reg);
        d_prod  = D_W'(s2_delta_reg) * signed'(D_W'(deriv_gain_reg));
        // derivative only ever brakes
        d_brake = (d_prod > D_W'(0)) ? '0 : d_prod;
    end

    logic signed [P_W-1:0] s3_p_reg;
    logic [I_W-1:0]        s3_i_reg;
    logic signed [D_W-1:0] s3_d_reg;

    always_ff @(posedge aclk) begin
        if (v2_reg && s3_free) begin
            s3_p_reg <= p_prod;
            s3_i_reg <= i_prod;
            s3_d_reg <= d_brake;
        end
    end

    // stage 3 -> result: sum, scale toward zero, saturate
    logic signed [SUM_W-1:0]   sum, sum_b, p_b;
    logic signed [SUMQ_W-1:0]  sum_q;
    logic signed [PQ_W-1:0]    p_q;
    logic signed [DQ_W-1:0]    d_q;
    logic signed [D_W-1:0]     d_b;
    logic [DUTY_W-1:0]         duty_next;
    logic signed [PTERM_W-1:0] pterm_next;
    logic signed [DTERM_W-1:0] dterm_next;

    always_comb begin
        sum   = SUM_W'(s3_p_reg) + signed'(SUM_W'(s3_i_reg)) + SUM_W'(s3_d_reg);
        sum_b = sum + (sum[SUM_W-1] ? SUM_BIAS : SUM_W'(0));
        sum_q = SUMQ_W'(sum_b >>> TERM_SHIFT);
        p_b   = SUM_W'(s3_p_reg + (s3_p_reg[P_W-1] ? P_BIAS : P_W'(0)));
        p_q   = PQ_W'(p_b >>> TERM_SHIFT);
        d_b   = s3_d_reg + (s3_d_reg[D_W-1] ? D_BIAS : D_W'(0));
        d_q   = DQ_W'(d_b >>> TERM_SHIFT);

        if (sum_q < SUMQ_W'(0))
            duty_next = '0;
        else if (sum_q > SUMQ_W'(DUTY_MAX))
            duty_next = DUTY_W'(DUTY_MAX);
        else
            duty_next = sum_q[DUTY_W-1:0];

        if (p_q > PQ_W'(32767))
            pterm_next = PTERM_W'(32767);
        else if (p_q < -PQ_W'(32768))
            pterm_next = PTERM_W'(-32768);
        else
            pterm_next = p_q[PTERM_W-1:0];

        if (d_q < -DQ_W'(8192))
            dterm_next = DTERM_W'(-8192);
        else
            dterm_next = d_q[DTERM_W-1:0];
    end

    logic [DUTY_W-1:0]         duty_reg;
    logic signed [PTERM_W-1:0] pterm_reg;
    logic [ITERM_W-1:0]        iterm_reg;
    logic signed [DTERM_W-1:0] dterm_reg;

    always_ff @(posedge aclk) begin
        if (v3_reg && out_free) begin
            duty_reg  <= duty_next;
            pterm_reg <= pterm_next;
            iterm_reg <= s3_i_reg[TERM_SHIFT +: ITERM_W];
            dterm_reg <= dterm_next;
        end
    end

    assign m_duty       = duty_reg;
    assign m_prop_term  = pterm_reg;
    assign m_integ_term = iterm_reg;
    assign m_deriv_term = dterm_reg;

endmodule

// ----- rtl/hpid_history.sv -----
// Measurement window of the heater PID controller and the windowed slope.
// Depends on hpid_pkg.
module hpid_history
    import hpid_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  hist_ctrl_t               ctrl,
    input  logic [MEAS_W-1:0]        meas,
    output logic signed [ERR_W-1:0]  delta
);

    // exact floor(m / HISTORY_DEPTH) for m < 2**MEAS_W by reciprocal multiply
    localparam int DIV_SHIFT = MEAS_W + $clog2(HISTORY_DEPTH);
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((1 << DIV_SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH);
    localparam int PROD_W    = MEAS_W + RECIP_W;

    logic [MEAS_W-1:0]        hist_reg [HISTORY_DEPTH];
    logic [MEAS_W-1:0]        oldest;
    logic signed [ERR_W-1:0]  diff;
    logic [MEAS_W-1:0]        mag;
    logic [PROD_W-1:0]        prod;
    logic [MEAS_W-1:0]        quo;

    // window is never cleared; aresetn only blocks a shift, priming upstream refills it
    always_ff @(posedge aclk) begin
        if (aresetn && ctrl.shift) begin
            for (int k = 0; k < HISTORY_DEPTH - 1; k++) begin
                hist_reg[k] <= ctrl.prime ? meas : hist_reg[k+1];
            end
            hist_reg[HISTORY_DEPTH-1] <= meas;
        end
    end

    always_comb begin
        oldest = ctrl.prime ? meas : hist_reg[0];
        diff   = signed'({1'b0, oldest}) - signed'({1'b0, meas});
        mag    = diff[ERR_W-1] ? MEAS_W'(-diff) : diff[MEAS_W-1:0];
        prod   = PROD_W'(mag) * PROD_W'(DIV_RECIP);
        quo    = prod[DIV_SHIFT +: MEAS_W];
        // truncation toward zero: divide the magnitude, restore the sign
        delta  = diff[ERR_W-1] ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
    end

endmodule
